@@ sv/wsg_pkg.sv @@
package wsg_pkg;

    localparam int RAM_BYTES = 128;
    localparam int RAM_AW    = 7;
    localparam int FREQ_W    = 18;
    localparam int PROD_W    = 28;

    localparam logic [19:0] MIX_GAIN = 20'd576716;
    localparam logic [6:0]  NCH_ADDR = 7'h7F;

    // byte offsets inside a channel's register block
    localparam logic [2:0] OFS_F0  = 3'd0;
    localparam logic [2:0] OFS_F1  = 3'd2;
    localparam logic [2:0] OFS_CTL = 3'd4;
    localparam logic [2:0] OFS_OFF = 3'd6;
    localparam logic [2:0] OFS_VOL = 3'd7;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_ADDR  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ADDR_PORT,
        ADDR_CLR,
        ADDR_NCH,
        ADDR_CTL,
        ADDR_VOL,
        ADDR_F0,
        ADDR_F1,
        ADDR_OFF,
        ADDR_NIB
    } addr_sel_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_RDL,
        ST_TN,
        ST_TNL,
        ST_CH,
        ST_CTL,
        ST_VOL,
        ST_CHK,
        ST_F1,
        ST_OFF,
        ST_NIBA,
        ST_NIB,
        ST_MUL,
        ST_HALF,
        ST_SUM,
        ST_MOD,
        ST_PH,
        ST_RNIBA,
        ST_RNIB,
        ST_RMUL,
        ST_STORE,
        ST_FIN
    } state_t;

    typedef struct packed {
        addr_sel_t addr_sel;
        logic      ram_we;
        logic      clr_inc;
        logic      ld_addr_port;
        logic      bump_addr;
        logic      tick_init;
        logic      ld_n;
        logic      ld_state;
        logic      ld_ctl;
        logic      ld_vol;
        logic      ld_f0;
        logic      ld_f1;
        logic      ld_off;
        logic      ld_nv;
        logic      ld_prod;
        logic      acc_add;
        logic      cnt_dec;
        logic      cnt_reload;
        logic      sum_start;
        logic      mod_step;
        logic      ld_phase;
        logic      h_set;
        logic      h_clr;
        logic      store_state;
        logic      chan_next;
        logic      out_ld_read;
        logic      out_ld_tick;
    } wsg_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic ch_en;
        logic cnt_zero;
        logic mod_last;
        logic h_one;
        logic k_last;
        logic out_free;
    } wsg_stat_t;

endpackage

@@ sv/wsg_ram.sv @@
module wsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ sv/wsg_ctrl.sv @@
module wsg_ctrl
    import wsg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] kind,
    output logic       in_stall,
    input  wsg_stat_t  stat,
    output wsg_cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.addr_sel = ADDR_PORT;
        state_next = state_reg;
        in_stall   = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.addr_sel = ADDR_CLR;
                cmd.ram_we   = 1'b1;
                cmd.clr_inc  = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (kind_t'(kind))
                        KIND_TICK:  state_next = ST_TN;
                        KIND_ADDR:  cmd.ld_addr_port = 1'b1;
                        KIND_WRITE:
                        begin
                            cmd.ram_we    = 1'b1;
                            cmd.bump_addr = 1'b1;
                        end
                        KIND_READ:  state_next = ST_RD;
                    endcase
                end
            end
            ST_RD:
            begin
                state_next = ST_RDL;
            end
            ST_RDL:
            begin
                if (stat.out_free)
                begin
                    cmd.out_ld_read = 1'b1;
                    cmd.bump_addr   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_TN:
            begin
                cmd.addr_sel  = ADDR_NCH;
                cmd.tick_init = 1'b1;
                state_next    = ST_TNL;
            end
            ST_TNL:
            begin
                cmd.ld_n   = 1'b1;
                state_next = ST_CH;
            end
            ST_CH:
            begin
                cmd.addr_sel = ADDR_CTL;
                cmd.ld_state = 1'b1;
                state_next   = ST_CTL;
            end
            ST_CTL:
            begin
                cmd.ld_ctl   = 1'b1;
                cmd.addr_sel = ADDR_VOL;
                state_next   = ST_VOL;
            end
            ST_VOL:
            begin
                cmd.ld_vol   = 1'b1;
                cmd.addr_sel = ADDR_F0;
                state_next   = ST_CHK;
            end
            ST_CHK:
            begin
                if (!stat.ch_en)
                begin
                    if (stat.k_last)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        cmd.chan_next = 1'b1;
                        state_next    = ST_CH;
                    end
                end
                else
                begin
                    cmd.ld_f0    = 1'b1;
                    cmd.addr_sel = ADDR_F1;
                    state_next   = ST_F1;
                end
            end
            ST_F1:
            begin
                cmd.ld_f1    = 1'b1;
                cmd.addr_sel = ADDR_OFF;
                state_next   = ST_OFF;
            end
            ST_OFF:
            begin
                cmd.ld_off = 1'b1;
                cmd.h_clr  = 1'b1;
                state_next = ST_NIBA;
            end
            ST_NIBA:
            begin
                cmd.addr_sel = ADDR_NIB;
                state_next   = ST_NIB;
            end
            ST_NIB:
            begin
                cmd.ld_nv  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.ld_prod = 1'b1;
                state_next  = ST_HALF;
            end
            ST_HALF:
            begin
                cmd.acc_add = 1'b1;
                if (stat.cnt_zero)
                begin
                    state_next = ST_SUM;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    if (stat.h_one)
                    begin
                        state_next = ST_STORE;
                    end
                    else
                    begin
                        cmd.h_set  = 1'b1;
                        state_next = ST_HALF;
                    end
                end
            end
            ST_SUM:
            begin
                cmd.sum_start = 1'b1;
                state_next    = ST_MOD;
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last)
                begin
                    state_next = ST_PH;
                end
            end
            ST_PH:
            begin
                cmd.ld_phase = 1'b1;
                state_next   = ST_RNIBA;
            end
            ST_RNIBA:
            begin
                cmd.addr_sel = ADDR_NIB;
                state_next   = ST_RNIB;
            end
            ST_RNIB:
            begin
                cmd.ld_nv  = 1'b1;
                state_next = ST_RMUL;
            end
            ST_RMUL:
            begin
                cmd.ld_prod    = 1'b1;
                cmd.cnt_reload = 1'b1;
                if (stat.h_one)
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    cmd.h_set  = 1'b1;
                    state_next = ST_HALF;
                end
            end
            ST_STORE:
            begin
                cmd.store_state = 1'b1;
                if (stat.k_last)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.chan_next = 1'b1;
                    state_next    = ST_CH;
                end
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_ld_tick = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/wsg_dp.sv @@
module wsg_dp
    import wsg_pkg::*;
#(
    parameter int CHANNELS            = 8,
    parameter int PHASE_FRACTION_BITS = 17
) (
    input  logic        clk,
    input  logic        rst_n,
    input  wsg_cmd_t    cmd,
    output wsg_stat_t   stat,
    input  logic [7:0]  write_data,
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [7:0]  read_data,
    output logic [14:0] mix_sample
);

    localparam int PFB       = PHASE_FRACTION_BITS;
    localparam int PH_W      = PFB + 5;
    localparam int SUM_W     = ((PH_W > FREQ_W) ? PH_W : FREQ_W) + 1;
    localparam int MOD_STEPS = SUM_W - PFB - 2;
    localparam int STEP_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
    localparam int DIV_W     = SUM_W + 3;
    localparam int FIRST_CH  = 8 - CHANNELS;

    logic [RAM_AW-1:0] ram_addr;
    logic              ram_we;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    logic [7:0]        addr_port_reg;
    logic [6:0]        clr_reg;
    logic [7:0]        mute_reg;
    logic [PH_W-1:0]   phase_arr [8];
    logic [6:0]        cnt_arr   [8];

    logic [2:0]        n_reg;
    logic [2:0]        k_reg;
    logic [7:0]        ctl_reg;
    logic [3:0]        vol_reg;
    logic [7:0]        f0_reg;
    logic [7:0]        f1_reg;
    logic [7:0]        off_reg;
    logic [PH_W-1:0]   phase_reg;
    logic [6:0]        cnt_reg;
    logic [7:0]        nv_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [14:0]       acc_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [STEP_W-1:0] step_reg;
    logic              h_reg;
    logic              out_valid_reg;
    logic [7:0]        read_data_reg;
    logic [14:0]       mix_sample_reg;

    logic [2:0]        ch;
    logic [7:0]        idx;
    logic [3:0]        nib;
    logic [5:0]        len;
    logic [FREQ_W-1:0] freq;
    logic [6:0]        reload;
    logic [7:0]        addr_bumped;

    assign ch     = ~k_reg;
    assign idx    = off_reg + {3'b000, phase_reg[PH_W-1 -: 5]};
    assign nib    = idx[0] ? ram_rdata[7:4] : ram_rdata[3:0];
    assign len    = {2'b00, 4'd8 - {1'b0, ctl_reg[4:2]}} << 2;
    assign freq   = {ctl_reg[1:0], f1_reg, f0_reg};
    assign reload = 7'(({4'b0000, n_reg} + 7'd1) * 7'd15);
    assign addr_bumped = {addr_port_reg[7], addr_port_reg[6:0] + 7'd1};

    always_comb
    begin
        unique case (cmd.addr_sel)
            ADDR_PORT: ram_addr = addr_port_reg[6:0];
            ADDR_CLR:  ram_addr = clr_reg;
            ADDR_NCH:  ram_addr = NCH_ADDR;
            ADDR_CTL:  ram_addr = {1'b1, ch, OFS_CTL};
            ADDR_VOL:  ram_addr = {1'b1, ch, OFS_VOL};
            ADDR_F0:   ram_addr = {1'b1, ch, OFS_F0};
            ADDR_F1:   ram_addr = {1'b1, ch, OFS_F1};
            ADDR_OFF:  ram_addr = {1'b1, ch, OFS_OFF};
            ADDR_NIB:  ram_addr = idx[7:1];
            default:   ram_addr = addr_port_reg[6:0];
        endcase
    end

    assign ram_we    = cmd.ram_we;
    assign ram_wdata = cmd.clr_inc ? 8'h00 : write_data;

    wsg_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_port_reg <= '0;
            clr_reg       <= '0;
            mute_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                phase_arr[i] <= '0;
                cnt_arr[i]   <= '0;
            end
        end
        else
        begin
            if (cmd.clr_inc)
            begin
                clr_reg <= clr_reg + 7'd1;
            end
            if (cfg_write_en)
            begin
                mute_reg <= cfg_write_data;
            end
            if (cmd.ld_addr_port)
            begin
                addr_port_reg <= write_data;
            end
            else if (cmd.bump_addr && addr_port_reg[7])
            begin
                addr_port_reg <= addr_bumped;
            end
            if (cmd.store_state)
            begin
                phase_arr[ch] <= phase_reg;
                cnt_arr[ch]   <= cnt_reg;
            end
            if (cmd.out_ld_read || cmd.out_ld_tick)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick_init)
        begin
            k_reg   <= '0;
            acc_reg <= '0;
        end
        if (cmd.chan_next)
        begin
            k_reg <= k_reg + 3'd1;
        end
        if (cmd.ld_n)
        begin
            n_reg <= ram_rdata[6:4];
        end
        if (cmd.ld_ctl)
        begin
            ctl_reg <= ram_rdata;
        end
        if (cmd.ld_vol)
        begin
            vol_reg <= ram_rdata[3:0];
        end
        if (cmd.ld_f0)
        begin
            f0_reg <= ram_rdata;
        end
        if (cmd.ld_f1)
        begin
            f1_reg <= ram_rdata;
        end
        if (cmd.ld_off)
        begin
            off_reg <= ram_rdata;
        end
        if (cmd.ld_state)
        begin
            phase_reg <= phase_arr[ch];
            cnt_reg   <= cnt_arr[ch];
        end
        else if (cmd.ld_phase)
        begin
            phase_reg <= sum_reg[PH_W-1:0];
        end
        if (cmd.cnt_reload)
        begin
            cnt_reg <= reload - 7'd1;
        end
        else if (cmd.cnt_dec)
        begin
            cnt_reg <= cnt_reg - 7'd1;
        end
        if (cmd.ld_nv)
        begin
            nv_reg <= {4'h0, nib} * {4'h0, vol_reg};
        end
        if (cmd.ld_prod)
        begin
            prod_reg <= PROD_W'(nv_reg) * PROD_W'(MIX_GAIN);
        end
        if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + 15'(prod_reg[PROD_W-1:16]);
        end
        if (cmd.h_clr)
        begin
            h_reg <= 1'b0;
        end
        else if (cmd.h_set)
        begin
            h_reg <= 1'b1;
        end
        // restoring reduction modulo length, one shifted subtract per cycle
        if (cmd.sum_start)
        begin
            sum_reg  <= SUM_W'(phase_reg) + SUM_W'(freq);
            div_reg  <= DIV_W'(len) << (PFB + MOD_STEPS - 1);
            step_reg <= '0;
        end
        else if (cmd.mod_step)
        begin
            if (DIV_W'(sum_reg) >= div_reg)
            begin
                sum_reg <= sum_reg - SUM_W'(div_reg);
            end
            div_reg  <= div_reg >> 1;
            step_reg <= step_reg + STEP_W'(1);
        end
        if (cmd.out_ld_read)
        begin
            read_data_reg  <= ram_rdata;
            mix_sample_reg <= '0;
        end
        else if (cmd.out_ld_tick)
        begin
            read_data_reg  <= '0;
            mix_sample_reg <= acc_reg;
        end
    end

    always_comb
    begin
        stat.clr_last = (clr_reg == 7'h7F);
        stat.ch_en    = (ctl_reg[7:5] != 3'b000) && (vol_reg != 4'h0) && !mute_reg[ch]
                        && ({1'b0, ch} >= 4'(FIRST_CH));
        stat.cnt_zero = (cnt_reg == 7'd0);
        stat.mod_last = (step_reg == STEP_W'(MOD_STEPS - 1));
        stat.h_one    = h_reg;
        stat.k_last   = (k_reg == n_reg);
        stat.out_free = !out_valid_reg || !out_stall;
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = read_data_reg;
    assign mix_sample = mix_sample_reg;

endmodule

@@ sv/wavetable_sound_generator_8ch.sv @@
// channel  | signals                                  | direction
// ---------+------------------------------------------+----------
// in       | in_valid, in_stall, kind, write_data     | host -> block
// out      | out_valid, out_stall, read_data, mix_sample | block -> host
// cfg      | cfg_write_en, cfg_write_data             | host -> block
//
// after reset all 128 wave ram bytes are cleared; in_stall stays high meanwhile
// address and data port writes are taken in the idle state; a data port read passes ST_RD
// and ST_RDL; a tick reads the channel count, per channel ctl and vol, if enabled f0, f1,
// offset, with mod steps (4 at 17 fraction bits) per phase step; one ram port serialises it
// a finished result holds in the output register while out_stall is high; the next
// result waits for it, writes still go through
module wavetable_sound_generator_8ch
    import wsg_pkg::*;
#(
    parameter int CHANNELS            = 8,
    parameter int PHASE_FRACTION_BITS = 17
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic [14:0] mix_sample,
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data
);

    wsg_cmd_t  cmd;
    wsg_stat_t stat;

    wsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    wsg_dp #(
        .CHANNELS            (CHANNELS),
        .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .write_data     (write_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .read_data      (read_data),
        .mix_sample     (mix_sample)
    );

endmodule

@@ sv/wsg_chk.sv @@
module wsg_chk
    import wsg_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  kind,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  read_data,
    input logic [14:0] mix_sample
);

    // a tick transaction keeps in_stall high in the cycle after it is taken
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind == KIND_TICK) |=> in_stall)
        else $error("input taken right after a tick");

    // a result is either a read byte or a mix, never both
    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (read_data == 8'h00) || (mix_sample == 15'd0))
        else $error("read and mix both nonzero");

    a_mix_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mix_sample <= 15'd31680))
        else $error("mix out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled result dropped");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(read_data) && $stable(mix_sample))
        else $error("stalled result changed");

endmodule

bind wavetable_sound_generator_8ch wsg_chk u_wsg_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .mix_sample (mix_sample)
);
